[hw/rtl/assert_macros.svh]
// Assertion macros for the RTL files; the decode stage core includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("assertion failed");

`endif

[hw/rtl/rv32dec_pkg.sv]
// Opcodes, select codes, decode record and decode function for the RV32I decode stage.
`default_nettype none

package rv32dec_pkg;

    localparam logic [6:0] OPC_OP_IMM = 7'h13;
    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_OP     = 7'h33;
    localparam logic [6:0] OPC_JAL    = 7'h6F;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_STORE  = 7'h23;

    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_ALT  = 7'h20;

    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;

    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;
    localparam logic [2:0] F3_BLTU = 3'd6;
    localparam logic [2:0] F3_BGEU = 3'd7;

    localparam logic [2:0] F3_BYTE  = 3'd0;
    localparam logic [2:0] F3_HALF  = 3'd1;
    localparam logic [2:0] F3_WORD  = 3'd2;
    localparam logic [2:0] F3_BYTEU = 3'd4;
    localparam logic [2:0] F3_HALFU = 3'd5;

    localparam logic [1:0] ASEL_RS1  = 2'd0;
    localparam logic [1:0] ASEL_PC   = 2'd1;
    localparam logic [1:0] ASEL_ZERO = 2'd2;

    localparam logic BSEL_RS2 = 1'b0;
    localparam logic BSEL_IMM = 1'b1;

    localparam logic [3:0] ALU_ADD   = 4'd0;
    localparam logic [3:0] ALU_SUB   = 4'd1;
    localparam logic [3:0] ALU_SLL   = 4'd2;
    localparam logic [3:0] ALU_SLT   = 4'd3;
    localparam logic [3:0] ALU_SLTU  = 4'd4;
    localparam logic [3:0] ALU_XOR   = 4'd5;
    localparam logic [3:0] ALU_SRL   = 4'd6;
    localparam logic [3:0] ALU_SRA   = 4'd7;
    localparam logic [3:0] ALU_OR    = 4'd8;
    localparam logic [3:0] ALU_AND   = 4'd9;
    localparam logic [3:0] ALU_ADDC0 = 4'd10;

    localparam logic [2:0] CMP_NONE   = 3'd0;
    localparam logic [2:0] CMP_ALWAYS = 3'd1;
    localparam logic [2:0] CMP_EQ     = 3'd2;
    localparam logic [2:0] CMP_NE     = 3'd3;
    localparam logic [2:0] CMP_LT     = 3'd4;
    localparam logic [2:0] CMP_LTU    = 3'd5;
    localparam logic [2:0] CMP_GE     = 3'd6;
    localparam logic [2:0] CMP_GEU    = 3'd7;

    localparam logic [3:0] MEM_NONE = 4'd0;
    localparam logic [3:0] MEM_LB   = 4'd1;
    localparam logic [3:0] MEM_LBU  = 4'd2;
    localparam logic [3:0] MEM_LH   = 4'd3;
    localparam logic [3:0] MEM_LHU  = 4'd4;
    localparam logic [3:0] MEM_LW   = 4'd5;
    localparam logic [3:0] MEM_SB   = 4'd6;
    localparam logic [3:0] MEM_SH   = 4'd7;
    localparam logic [3:0] MEM_SW   = 4'd8;

    localparam logic [1:0] WB_NONE = 2'd0;
    localparam logic [1:0] WB_ALU  = 2'd1;
    localparam logic [1:0] WB_PC4  = 2'd2;
    localparam logic [1:0] WB_MEM  = 2'd3;

    typedef struct packed {
        logic        illegal;
        logic [4:0]  dest_reg;
        logic [31:0] src1_value;
        logic [31:0] src2_value;
        logic [31:0] immediate;
        logic [1:0]  alu_a_select;
        logic        alu_b_select;
        logic [3:0]  alu_operation;
        logic [2:0]  compare_kind;
        logic [3:0]  memory_kind;
        logic [1:0]  writeback_kind;
    } dec_t;

    function automatic dec_t decode_instr(
        input logic [31:0] w,
        input logic [31:0] rs1_val,
        input logic [31:0] rs2_val
    );
        dec_t        d;
        logic        bad;
        logic [6:0]  opc;
        logic [6:0]  f7;
        logic [2:0]  f3;
        logic [31:0] imm_i;
        logic [31:0] imm_s;
        logic [31:0] imm_b;
        logic [31:0] imm_j;
        logic [31:0] imm_u;
        logic [31:0] shamt;
        d     = '0;
        bad   = 1'b0;
        opc   = w[6:0];
        f3    = w[14:12];
        f7    = w[31:25];
        imm_i = {{20{w[31]}}, w[31:20]};
        imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
        imm_b = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
        imm_j = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
        imm_u = {w[31:12], 12'b0};
        shamt = {27'b0, w[24:20]};
        unique case (opc)
            OPC_OP_IMM:
            begin
                d.dest_reg       = w[11:7];
                d.src1_value     = rs1_val;
                d.alu_b_select   = BSEL_IMM;
                d.writeback_kind = WB_ALU;
                d.immediate      = imm_i;
                unique case (f3)
                    F3_ADD:  d.alu_operation = ALU_ADD;
                    F3_SLT:  d.alu_operation = ALU_SLT;
                    F3_SLTU: d.alu_operation = ALU_SLTU;
                    F3_XOR:  d.alu_operation = ALU_XOR;
                    F3_OR:   d.alu_operation = ALU_OR;
                    F3_AND:  d.alu_operation = ALU_AND;
                    F3_SLL:
                    begin
                        d.alu_operation = ALU_SLL;
                        d.immediate     = shamt;
                        bad             = (f7 != F7_BASE);
                    end
                    default:
                    begin
                        d.immediate = shamt;
                        if (f7 == F7_BASE)
                            d.alu_operation = ALU_SRL;
                        else if (f7 == F7_ALT)
                            d.alu_operation = ALU_SRA;
                        else
                            bad = 1'b1;
                    end
                endcase
            end
            OPC_LUI:
            begin
                d.dest_reg       = w[11:7];
                d.immediate      = imm_u;
                d.alu_a_select   = ASEL_ZERO;
                d.alu_b_select   = BSEL_IMM;
                d.writeback_kind = WB_ALU;
            end
            OPC_AUIPC:
            begin
                d.dest_reg       = w[11:7];
                d.immediate      = imm_u;
                d.alu_a_select   = ASEL_PC;
                d.alu_b_select   = BSEL_IMM;
                d.writeback_kind = WB_ALU;
            end
            OPC_OP:
            begin
                d.dest_reg       = w[11:7];
                d.src1_value     = rs1_val;
                d.src2_value     = rs2_val;
                d.writeback_kind = WB_ALU;
                unique case (f3)
                    F3_ADD:
                    begin
                        if (f7 == F7_BASE)
                            d.alu_operation = ALU_ADD;
                        else if (f7 == F7_ALT)
                            d.alu_operation = ALU_SUB;
                        else
                            bad = 1'b1;
                    end
                    F3_SR:
                    begin
                        if (f7 == F7_BASE)
                            d.alu_operation = ALU_SRL;
                        else if (f7 == F7_ALT)
                            d.alu_operation = ALU_SRA;
                        else
                            bad = 1'b1;
                    end
                    F3_SLL:  d.alu_operation = ALU_SLL;
                    F3_SLT:  d.alu_operation = ALU_SLT;
                    F3_SLTU: d.alu_operation = ALU_SLTU;
                    F3_XOR:  d.alu_operation = ALU_XOR;
                    F3_OR:   d.alu_operation = ALU_OR;
                    default: d.alu_operation = ALU_AND;
                endcase
                if (f3 != F3_ADD && f3 != F3_SR && f7 != F7_BASE)
                    bad = 1'b1;
            end
            OPC_JAL:
            begin
                d.dest_reg       = w[11:7];
                d.immediate      = imm_j;
                d.alu_a_select   = ASEL_PC;
                d.alu_b_select   = BSEL_IMM;
                d.compare_kind   = CMP_ALWAYS;
                d.writeback_kind = WB_PC4;
            end
            OPC_JALR:
            begin
                d.dest_reg       = w[11:7];
                d.src1_value     = rs1_val;
                d.immediate      = imm_i;
                d.alu_b_select   = BSEL_IMM;
                d.alu_operation  = ALU_ADDC0;
                d.compare_kind   = CMP_ALWAYS;
                d.writeback_kind = WB_PC4;
                bad              = (f3 != 3'd0);
            end
            OPC_BRANCH:
            begin
                d.src1_value   = rs1_val;
                d.src2_value   = rs2_val;
                d.immediate    = imm_b;
                d.alu_a_select = ASEL_PC;
                d.alu_b_select = BSEL_IMM;
                unique case (f3)
                    F3_BEQ:  d.compare_kind = CMP_EQ;
                    F3_BNE:  d.compare_kind = CMP_NE;
                    F3_BLT:  d.compare_kind = CMP_LT;
                    F3_BGE:  d.compare_kind = CMP_GE;
                    F3_BLTU: d.compare_kind = CMP_LTU;
                    F3_BGEU: d.compare_kind = CMP_GEU;
                    default: bad = 1'b1;
                endcase
            end
            OPC_LOAD:
            begin
                d.dest_reg       = w[11:7];
                d.src1_value     = rs1_val;
                d.immediate      = imm_i;
                d.alu_b_select   = BSEL_IMM;
                d.writeback_kind = WB_MEM;
                unique case (f3)
                    F3_BYTE:  d.memory_kind = MEM_LB;
                    F3_BYTEU: d.memory_kind = MEM_LBU;
                    F3_HALF:  d.memory_kind = MEM_LH;
                    F3_HALFU: d.memory_kind = MEM_LHU;
                    F3_WORD:  d.memory_kind = MEM_LW;
                    default:  bad = 1'b1;
                endcase
            end
            OPC_STORE:
            begin
                d.src1_value   = rs1_val;
                d.src2_value   = rs2_val;
                d.immediate    = imm_s;
                d.alu_b_select = BSEL_IMM;
                unique case (f3)
                    F3_BYTE: d.memory_kind = MEM_SB;
                    F3_HALF: d.memory_kind = MEM_SH;
                    F3_WORD: d.memory_kind = MEM_SW;
                    default: bad = 1'b1;
                endcase
            end
            default:
            begin
                bad = 1'b1;
            end
        endcase
        if (bad)
        begin
            d         = '0;
            d.illegal = 1'b1;
        end
        return d;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/rv32i_decode_stage_core.sv]
// RV32I decode stage: register file, operand read and instruction decode.
`default_nettype none

// Takes one item per clock unless stalled. The input stalls only while the
// operand register is full and the result register holds a result that has not
// been taken. A decode item reads both source registers from a 32-entry register
// file at the edge it is accepted. Once the result register is free or being
// taken, it decodes the held instruction and loads the result register, which
// drives out_valid. A write item updates the register file at its own transfer
// and yields no result; a decode accepted after it already sees the new value.
// Register 0 always reads zero. The register file is cleared by reset through
// one valid flag per entry, with no clearing pass.
module rv32i_decode_stage_core
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         in_valid,
    output logic        in_ready,
    input  wire         mode,
    input  wire  [31:0] instruction,
    input  wire  [4:0]  write_index,
    input  wire  [31:0] write_value,
    output logic        out_valid,
    input  wire         out_ready,
    output logic        illegal,
    output logic [4:0]  dest_reg,
    output logic [31:0] src1_value,
    output logic [31:0] src2_value,
    output logic [31:0] immediate,
    output logic [1:0]  alu_a_select,
    output logic        alu_b_select,
    output logic [3:0]  alu_operation,
    output logic [2:0]  compare_kind,
    output logic [3:0]  memory_kind,
    output logic [1:0]  writeback_kind
);
    import rv32dec_pkg::*;

    logic [31:0] rf_mem_reg [32];
    logic [31:0] rf_valid_reg;
    logic [31:0] rf_valid_next;

    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic [31:0] instr_reg;
    logic [31:0] rs1_data_reg;
    logic [31:0] rs2_data_reg;
    logic        rs1_ok_reg;
    logic        rs2_ok_reg;

    logic        out_valid_reg;
    logic        out_valid_next;
    dec_t        out_reg;
    dec_t        dec_next;

    logic        in_fire;
    logic        dec_load;
    logic        wr_fire;
    logic        s1_move;

    logic        out_is_store;
    logic        out_rest_zero;

    assign s1_move  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_move;
    assign in_fire  = in_valid && in_ready;
    assign dec_load = in_fire && !mode;
    assign wr_fire  = in_fire && mode && (write_index != 5'd0);

    always_comb
    begin
        rf_valid_next = rf_valid_reg;
        if (wr_fire)
            rf_valid_next[write_index] = 1'b1;
    end

    always_comb
    begin
        if (dec_load)
            s1_valid_next = 1'b1;
        else if (s1_move)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    always_comb
    begin
        if (s1_move)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_comb
    begin
        dec_next = decode_instr(instr_reg,
                                rs1_ok_reg ? rs1_data_reg : 32'd0,
                                rs2_ok_reg ? rs2_data_reg : 32'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rf_valid_reg  <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rf_valid_reg  <= rf_valid_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_fire)
            rf_mem_reg[write_index] <= write_value;
        if (dec_load)
        begin
            rs1_data_reg <= rf_mem_reg[instruction[19:15]];
            rs2_data_reg <= rf_mem_reg[instruction[24:20]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (dec_load)
        begin
            instr_reg  <= instruction;
            rs1_ok_reg <= rf_valid_reg[instruction[19:15]];
            rs2_ok_reg <= rf_valid_reg[instruction[24:20]];
        end
        if (s1_move)
            out_reg <= dec_next;
    end

    assign out_valid      = out_valid_reg;
    assign illegal        = out_reg.illegal;
    assign dest_reg       = out_reg.dest_reg;
    assign src1_value     = out_reg.src1_value;
    assign src2_value     = out_reg.src2_value;
    assign immediate      = out_reg.immediate;
    assign alu_a_select   = out_reg.alu_a_select;
    assign alu_b_select   = out_reg.alu_b_select;
    assign alu_operation  = out_reg.alu_operation;
    assign compare_kind   = out_reg.compare_kind;
    assign memory_kind    = out_reg.memory_kind;
    assign writeback_kind = out_reg.writeback_kind;

    assign out_is_store  = out_reg.memory_kind inside {MEM_SB, MEM_SH, MEM_SW};
    assign out_rest_zero = (out_reg[$bits(dec_t)-2:0] == '0);

`include "assert_macros.svh"

    `ASSERT_NEVER(a_reg0_never_valid, clk, rst_n, rf_valid_reg[0])
    `ASSERT_CLK(a_s1_stall_holds, clk, rst_n, s1_valid_reg && !s1_move |=> s1_valid_reg)
    `ASSERT_CLK(a_illegal_clears_fields, clk, rst_n, out_valid && illegal |-> out_rest_zero)
    `ASSERT_CLK(a_store_no_writeback, clk, rst_n, out_valid && out_is_store |-> writeback_kind == WB_NONE)

endmodule

`default_nettype wire

[tb/rv32i_decode_stage_core_tb.sv]
// Self-checking testbench for the RV32I decode stage with its register file.
`timescale 1ns / 1ps

module rv32i_decode_stage_core_tb;
    import rv32dec_pkg::*;

    localparam logic [6:0]  OPC_FENCE   = 7'h0F;
    localparam logic [6:0]  OPC_SYSTEM  = 7'h73;
    localparam logic        MODE_DECODE = 1'b0;
    localparam logic        MODE_WRITE  = 1'b1;
    localparam int unsigned LONG_HOLD   = 120;
    localparam int unsigned IDLE_LIMIT  = 1000;
    localparam int unsigned NUM_RANDOM  = 1425;

    typedef struct {
        logic        mode;
        logic [31:0] instruction;
        logic [4:0]  write_index;
        logic [31:0] write_value;
        int unsigned gap;
        bit          drain_first;
        bit          hold_sink;
    } stage_item_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        mode = 1'b0;
    logic [31:0] instruction = '0;
    logic [4:0]  write_index = '0;
    logic [31:0] write_value = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        illegal;
    logic [4:0]  dest_reg;
    logic [31:0] src1_value;
    logic [31:0] src2_value;
    logic [31:0] immediate;
    logic [1:0]  alu_a_select;
    logic        alu_b_select;
    logic [3:0]  alu_operation;
    logic [2:0]  compare_kind;
    logic [3:0]  memory_kind;
    logic [1:0]  writeback_kind;

    logic        hold_sink_req = 1'b0;

    stage_item_t pending_items[$];
    dec_t        expected_decodes[$];
    logic [31:0] model_regs [32];
    int          error_count = 0;
    int          results_seen = 0;

    stage_item_t head_item;
    bit          took;
    bit          offer;
    bit          hit_hold;
    int unsigned tx_wait;
    bit          tx_armed;
    int unsigned rx_wait;
    int unsigned hold_left;
    dec_t        seen_dec;
    dec_t        want_dec;

    rv32i_decode_stage_core i_dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .mode           (mode),
        .instruction    (instruction),
        .write_index    (write_index),
        .write_value    (write_value),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .illegal        (illegal),
        .dest_reg       (dest_reg),
        .src1_value     (src1_value),
        .src2_value     (src2_value),
        .immediate      (immediate),
        .alu_a_select   (alu_a_select),
        .alu_b_select   (alu_b_select),
        .alu_operation  (alu_operation),
        .compare_kind   (compare_kind),
        .memory_kind    (memory_kind),
        .writeback_kind (writeback_kind)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [31:0] r_word(
        input logic [6:0] f7,
        input logic [4:0] rs2,
        input logic [4:0] rs1,
        input logic [2:0] f3,
        input logic [4:0] rd,
        input logic [6:0] opc
    );
        return {f7, rs2, rs1, f3, rd, opc};
    endfunction

    function automatic dec_t predict_decode(input logic [31:0] w);
        dec_t        r;
        logic        bad;
        logic [6:0]  opc;
        logic [6:0]  f7;
        logic [2:0]  f3;
        logic [31:0] rs1v;
        logic [31:0] rs2v;
        logic [31:0] imm_i;
        logic [31:0] shamt;
        r     = '0;
        bad   = 1'b0;
        opc   = w[6:0];
        f3    = w[14:12];
        f7    = w[31:25];
        rs1v  = model_regs[w[19:15]];
        rs2v  = model_regs[w[24:20]];
        imm_i = {{20{w[31]}}, w[31:20]};
        shamt = {27'd0, w[24:20]};
        case (opc)
            OPC_OP_IMM:
            begin
                r.dest_reg       = w[11:7];
                r.src1_value     = rs1v;
                r.alu_b_select   = BSEL_IMM;
                r.writeback_kind = WB_ALU;
                r.immediate      = imm_i;
                case (f3)
                    F3_ADD:  r.alu_operation = ALU_ADD;
                    F3_SLT:  r.alu_operation = ALU_SLT;
                    F3_SLTU: r.alu_operation = ALU_SLTU;
                    F3_XOR:  r.alu_operation = ALU_XOR;
                    F3_OR:   r.alu_operation = ALU_OR;
                    F3_AND:  r.alu_operation = ALU_AND;
                    F3_SLL:
                    begin
                        r.alu_operation = ALU_SLL;
                        r.immediate     = shamt;
                        bad             = (f7 != F7_BASE);
                    end
                    default:
                    begin
                        r.immediate     = shamt;
                        r.alu_operation = (f7 == F7_ALT) ? ALU_SRA : ALU_SRL;
                        bad             = (f7 != F7_BASE && f7 != F7_ALT);
                    end
                endcase
            end
            OPC_LUI, OPC_AUIPC:
            begin
                r.dest_reg       = w[11:7];
                r.immediate      = {w[31:12], 12'd0};
                r.alu_a_select   = (opc == OPC_LUI) ? ASEL_ZERO : ASEL_PC;
                r.alu_b_select   = BSEL_IMM;
                r.writeback_kind = WB_ALU;
            end
            OPC_OP:
            begin
                r.dest_reg       = w[11:7];
                r.src1_value     = rs1v;
                r.src2_value     = rs2v;
                r.writeback_kind = WB_ALU;
                case (f3)
                    F3_ADD:  r.alu_operation = (f7 == F7_ALT) ? ALU_SUB : ALU_ADD;
                    F3_SR:   r.alu_operation = (f7 == F7_ALT) ? ALU_SRA : ALU_SRL;
                    F3_SLL:  r.alu_operation = ALU_SLL;
                    F3_SLT:  r.alu_operation = ALU_SLT;
                    F3_SLTU: r.alu_operation = ALU_SLTU;
                    F3_XOR:  r.alu_operation = ALU_XOR;
                    F3_OR:   r.alu_operation = ALU_OR;
                    default: r.alu_operation = ALU_AND;
                endcase
                if (f3 == F3_ADD || f3 == F3_SR)
                    bad = (f7 != F7_BASE && f7 != F7_ALT);
                else
                    bad = (f7 != F7_BASE);
            end
            OPC_JAL:
            begin
                r.dest_reg       = w[11:7];
                r.immediate      = {{12{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};
                r.alu_a_select   = ASEL_PC;
                r.alu_b_select   = BSEL_IMM;
                r.compare_kind   = CMP_ALWAYS;
                r.writeback_kind = WB_PC4;
            end
            OPC_JALR:
            begin
                r.dest_reg       = w[11:7];
                r.src1_value     = rs1v;
                r.immediate      = imm_i;
                r.alu_b_select   = BSEL_IMM;
                r.alu_operation  = ALU_ADDC0;
                r.compare_kind   = CMP_ALWAYS;
                r.writeback_kind = WB_PC4;
                bad              = (f3 != F3_ADD);
            end
            OPC_BRANCH:
            begin
                r.src1_value   = rs1v;
                r.src2_value   = rs2v;
                r.immediate    = {{20{w[31]}}, w[7], w[30:25], w[11:8], 1'b0};
                r.alu_a_select = ASEL_PC;
                r.alu_b_select = BSEL_IMM;
                case (f3)
                    F3_BEQ:  r.compare_kind = CMP_EQ;
                    F3_BNE:  r.compare_kind = CMP_NE;
                    F3_BLT:  r.compare_kind = CMP_LT;
                    F3_BGE:  r.compare_kind = CMP_GE;
                    F3_BLTU: r.compare_kind = CMP_LTU;
                    F3_BGEU: r.compare_kind = CMP_GEU;
                    default: bad = 1'b1;
                endcase
            end
            OPC_LOAD:
            begin
                r.dest_reg       = w[11:7];
                r.src1_value     = rs1v;
                r.immediate      = imm_i;
                r.alu_b_select   = BSEL_IMM;
                r.writeback_kind = WB_MEM;
                case (f3)
                    F3_BYTE:  r.memory_kind = MEM_LB;
                    F3_BYTEU: r.memory_kind = MEM_LBU;
                    F3_HALF:  r.memory_kind = MEM_LH;
                    F3_HALFU: r.memory_kind = MEM_LHU;
                    F3_WORD:  r.memory_kind = MEM_LW;
                    default:  bad = 1'b1;
                endcase
            end
            OPC_STORE:
            begin
                r.src1_value   = rs1v;
                r.src2_value   = rs2v;
                r.immediate    = {{20{w[31]}}, w[31:25], w[11:7]};
                r.alu_b_select = BSEL_IMM;
                case (f3)
                    F3_BYTE: r.memory_kind = MEM_SB;
                    F3_HALF: r.memory_kind = MEM_SH;
                    F3_WORD: r.memory_kind = MEM_SW;
                    default: bad = 1'b1;
                endcase
            end
            default:
            begin
                bad = 1'b1;
            end
        endcase
        if (bad)
        begin
            r         = '0;
            r.illegal = 1'b1;
        end
        return r;
    endfunction

    task automatic queue_item(
        input logic        item_mode,
        input logic [31:0] word,
        input logic [4:0]  idx,
        input logic [31:0] value,
        input int unsigned gap,
        input bit          drain_first,
        input bit          hold_sink
    );
        stage_item_t it;
        it.mode        = item_mode;
        it.instruction = word;
        it.write_index = idx;
        it.write_value = value;
        it.gap         = gap;
        it.drain_first = drain_first;
        it.hold_sink   = hold_sink;
        pending_items.push_back(it);
    endtask

    task automatic queue_decode(input logic [31:0] word);
        queue_item(MODE_DECODE, word, 5'($urandom), $urandom, $urandom_range(0, 13), 1'b0, 1'b0);
    endtask

    task automatic queue_write(input logic [4:0] idx, input logic [31:0] value);
        queue_item(MODE_WRITE, $urandom, idx, value, $urandom_range(0, 13), 1'b0, 1'b0);
    endtask

    task automatic report_mismatch(
        input string       field,
        input logic [31:0] got,
        input logic [31:0] want
    );
        error_count++;
        $display("[%0t] mismatch on %s: got %h, want %h", $time, field, got, want);
    endtask

    // Driver: offer the head of the queue after its gap, predict at transfer.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid      <= 1'b0;
            mode          <= 1'b0;
            instruction   <= '0;
            write_index   <= '0;
            write_value   <= '0;
            hold_sink_req <= 1'b0;
            tx_wait = 0;
            tx_armed = 1'b0;
            for (int i = 0; i < 32; i++)
                model_regs[i] = '0;
        end
        else
        begin
            took = in_valid && in_ready;
            hit_hold = 1'b0;
            if (took)
            begin
                head_item = pending_items.pop_front();
                hit_hold = head_item.hold_sink;
                tx_armed = 1'b0;
                if (head_item.mode == MODE_DECODE)
                    expected_decodes.push_back(predict_decode(head_item.instruction));
                else if (head_item.write_index != 5'd0)
                    model_regs[head_item.write_index] = head_item.write_value;
            end
            offer = in_valid && !took;
            if (!offer && pending_items.size() != 0)
            begin
                if (!tx_armed)
                begin
                    tx_wait = pending_items[0].gap;
                    tx_armed = 1'b1;
                end
                if (tx_wait != 0)
                    tx_wait--;
                else if (!pending_items[0].drain_first || expected_decodes.size() == 0)
                    offer = 1'b1;
            end
            if (offer)
            begin
                mode        <= pending_items[0].mode;
                instruction <= pending_items[0].instruction;
                write_index <= pending_items[0].write_index;
                write_value <= pending_items[0].write_value;
            end
            in_valid      <= offer;
            hold_sink_req <= hit_hold;
        end
    end

    // Monitor: compare each result transfer against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_wait = 0;
            hold_left = 0;
        end
        else
        begin
            if (hold_sink_req)
                hold_left = LONG_HOLD;
            if (out_valid && out_ready)
            begin
                seen_dec.illegal        = illegal;
                seen_dec.dest_reg       = dest_reg;
                seen_dec.src1_value     = src1_value;
                seen_dec.src2_value     = src2_value;
                seen_dec.immediate      = immediate;
                seen_dec.alu_a_select   = alu_a_select;
                seen_dec.alu_b_select   = alu_b_select;
                seen_dec.alu_operation  = alu_operation;
                seen_dec.compare_kind   = compare_kind;
                seen_dec.memory_kind    = memory_kind;
                seen_dec.writeback_kind = writeback_kind;
                if (expected_decodes.size() == 0)
                    report_mismatch("result with none expected", seen_dec.immediate, '0);
                else
                begin
                    want_dec = expected_decodes.pop_front();
                    if (seen_dec.illegal !== want_dec.illegal)
                        report_mismatch("illegal", 32'(seen_dec.illegal),
                                        32'(want_dec.illegal));
                    if (seen_dec.dest_reg !== want_dec.dest_reg)
                        report_mismatch("dest_reg", 32'(seen_dec.dest_reg),
                                        32'(want_dec.dest_reg));
                    if (seen_dec.src1_value !== want_dec.src1_value)
                        report_mismatch("src1_value", seen_dec.src1_value, want_dec.src1_value);
                    if (seen_dec.src2_value !== want_dec.src2_value)
                        report_mismatch("src2_value", seen_dec.src2_value, want_dec.src2_value);
                    if (seen_dec.immediate !== want_dec.immediate)
                        report_mismatch("immediate", seen_dec.immediate, want_dec.immediate);
                    if (seen_dec.alu_a_select !== want_dec.alu_a_select)
                        report_mismatch("alu_a_select", 32'(seen_dec.alu_a_select),
                                        32'(want_dec.alu_a_select));
                    if (seen_dec.alu_b_select !== want_dec.alu_b_select)
                        report_mismatch("alu_b_select", 32'(seen_dec.alu_b_select),
                                        32'(want_dec.alu_b_select));
                    if (seen_dec.alu_operation !== want_dec.alu_operation)
                        report_mismatch("alu_operation", 32'(seen_dec.alu_operation),
                                        32'(want_dec.alu_operation));
                    if (seen_dec.compare_kind !== want_dec.compare_kind)
                        report_mismatch("compare_kind", 32'(seen_dec.compare_kind),
                                        32'(want_dec.compare_kind));
                    if (seen_dec.memory_kind !== want_dec.memory_kind)
                        report_mismatch("memory_kind", 32'(seen_dec.memory_kind),
                                        32'(want_dec.memory_kind));
                    if (seen_dec.writeback_kind !== want_dec.writeback_kind)
                        report_mismatch("writeback_kind", 32'(seen_dec.writeback_kind),
                                        32'(want_dec.writeback_kind));
                end
                results_seen++;
                rx_wait = (((results_seen / 90) % 4) == 2) ? 0 : $urandom_range(0, 13);
            end
            else if (hold_left != 0)
                hold_left--;
            else if (rx_wait != 0)
                rx_wait--;
            out_ready <= (hold_left == 0 && rx_wait == 0);
        end
    end

    // Watchdog: end the run when no transfer happens for too long.
    initial
    begin
        int unsigned idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        logic [31:0] word;
        logic [31:0] value;
        int unsigned burst_left;
        int unsigned gap;
        bit          hold_here;

        queue_write(5'd0, 32'hFFFF_FFFF);
        queue_write(5'd31, 32'hFFFF_FFFF);
        queue_write(5'd1, 32'h8000_0000);
        queue_write(5'd2, 32'h0000_0001);
        queue_decode(r_word(F7_BASE, 5'd1, 5'd31, F3_ADD, 5'd31, OPC_OP));
        queue_decode(r_word(F7_ALT, 5'd31, 5'd2, F3_ADD, 5'd1, OPC_OP));
        queue_decode(r_word(F7_ALT, 5'd2, 5'd1, F3_SR, 5'd0, OPC_OP));
        queue_decode(r_word(F7_ALT, 5'd2, 5'd1, F3_SLL, 5'd3, OPC_OP));
        queue_decode(r_word(~F7_BASE, 5'd2, 5'd1, F3_ADD, 5'd3, OPC_OP));
        queue_decode(r_word(7'h40, 5'd0, 5'd0, F3_ADD, 5'd5, OPC_OP_IMM));
        queue_decode(r_word(F7_ALT, 5'd3, 5'd1, F3_SLL, 5'd5, OPC_OP_IMM));
        queue_decode(r_word(F7_ALT, 5'd31, 5'd1, F3_SR, 5'd6, OPC_OP_IMM));
        queue_decode(r_word(~F7_BASE, 5'd31, 5'd1, F3_SR, 5'd6, OPC_OP_IMM));
        queue_decode({20'hFFFFF, 5'd3, OPC_LUI});
        queue_decode({20'h00001, 5'd4, OPC_AUIPC});
        queue_decode({20'hFFFFF, 5'd31, OPC_JAL});
        queue_decode(r_word(7'h7F, 5'd31, 5'd31, F3_HALF, 5'd31, OPC_JALR));
        queue_decode(r_word(7'h3F, 5'd31, 5'd31, F3_ADD, 5'd7, OPC_JALR));
        queue_decode(r_word(7'h7F, 5'd31, 5'd1, F3_SLT, 5'd31, OPC_BRANCH));
        queue_decode(r_word(7'h7F, 5'd31, 5'd1, F3_BGEU, 5'd31, OPC_BRANCH));
        queue_decode(r_word(7'h7F, 5'd31, 5'd31, F3_SLTU, 5'd7, OPC_LOAD));
        queue_decode(r_word(7'h7F, 5'd31, 5'd31, F3_WORD, 5'd7, OPC_LOAD));
        queue_decode(r_word(7'h7F, 5'd31, 5'd1, F3_SLTU, 5'd31, OPC_STORE));
        queue_decode(r_word(7'h40, 5'd31, 5'd1, F3_WORD, 5'd31, OPC_STORE));
        queue_decode({25'd0, OPC_FENCE});
        queue_decode({25'd0, OPC_SYSTEM});
        queue_decode(32'hFFFF_FFFF);
        queue_decode(32'h0000_0000);

        burst_left = 0;
        for (int k = 0; k < NUM_RANDOM; k++)
        begin
            hold_here = (k == 400 || k == 1000);
            if (hold_here)
                burst_left = 40;
            if (burst_left != 0 || ((k / 100) % 4) == 3)
                gap = 0;
            else
                gap = $urandom_range(0, 13);
            if (burst_left != 0)
                burst_left--;
            word = $urandom;
            case ($urandom_range(0, 5))
                0:       value = 32'h0000_0000;
                1:       value = 32'hFFFF_FFFF;
                2:       value = 32'h8000_0000;
                default: value = $urandom;
            endcase
            if ($urandom_range(0, 4) == 0)
                queue_item(MODE_WRITE, word, 5'($urandom), value, gap, k == 0 || k == 700,
                           hold_here);
            else
            begin
                case ($urandom_range(0, 11))
                    0:  word[6:0] = OPC_OP_IMM;
                    1:  word[6:0] = OPC_LUI;
                    2:  word[6:0] = OPC_AUIPC;
                    3:  word[6:0] = OPC_OP;
                    4:  word[6:0] = OPC_JAL;
                    5:  word[6:0] = OPC_JALR;
                    6:  word[6:0] = OPC_BRANCH;
                    7:  word[6:0] = OPC_LOAD;
                    8:  word[6:0] = OPC_STORE;
                    9:  word[6:0] = OPC_FENCE;
                    10: word[6:0] = OPC_SYSTEM;
                    default: ;
                endcase
                if ((word[6:0] == OPC_OP || word[6:0] == OPC_OP_IMM)
                    && $urandom_range(0, 9) != 0)
                    word[31:25] = $urandom_range(0, 1) ? F7_ALT : F7_BASE;
                if (word[6:0] == OPC_JALR && $urandom_range(0, 3) != 0)
                    word[14:12] = F3_ADD;
                queue_item(MODE_DECODE, word, 5'($urandom), value, gap, k == 0 || k == 700,
                           hold_here);
            end
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_items.size() != 0 || expected_decodes.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (error_count == 0 && expected_decodes.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
